// ----- hw/rtl/mbe_pkg.sv -----
package mbe_pkg;

   localparam int FRAC_BITS  = 28;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_X_START    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_STEP     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_START    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITERS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH = 3'd5;

   localparam logic [15:0] MAX_ITERS_RESET  = 16'd256;
   localparam logic [12:0] LINE_WIDTH_RESET = 13'd4096;

   // 4.0 in Q8.56
   localparam logic [63:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

   typedef struct packed {
      logic [11:0] column;
      logic [11:0] row;
   } req_type;

   typedef struct packed {
      logic [15:0] iterations;
      logic [23:0] pixel_index;
      logic        written;
   } rsp_type;

   typedef struct packed {
      logic load_px;
      logic c_mul;
      logic c_add;
      logic z_mul;
      logic z_update;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic outside;
      logic stop;
   } status_type;

endpackage

// ----- hw/rtl/mandelbrot_escape_time.sv -----
// Path: an accepted word passes S_CMUL and S_CADD, then the iterations, then S_DONE,
// where the result is loaded into the registered response; a pixel outside the line skips the iterations.
// Handshake: one pixel at a time; a new word is taken only in S_IDLE, and S_DONE holds
// while an earlier response is still unaccepted; each iteration passes S_ZMUL for the three
// 32x32 products and then S_ZUPD for the update and escape test.
// Reset: synchronous, active high; CSR registers return to defaults, no word in flight.
module mandelbrot_escape_time (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  mbe_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output mbe_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_en,
   input  logic [mbe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbe_pkg::CSR_DATA_W-1:0] csr_data
);
   import mbe_pkg::*;

   cmd_type    cmd;
   status_type status;

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbe_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_data     (req_data),
      .rsp_data     (rsp_data),
      .cmd          (cmd),
      .status       (status)
   );

endmodule

// ----- hw/rtl/mbe_ctrl.sv -----
module mbe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  mbe_pkg::status_type status,
   output mbe_pkg::cmd_type    cmd
);
   import mbe_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CMUL  = 6'b000010,
      S_CADD  = 6'b000100,
      S_ZMUL  = 6'b001000,
      S_ZUPD  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_px = 1'b1;
               state_in    = S_CMUL;
            end
         end
         S_CMUL: begin
            cmd.c_mul = 1'b1;
            state_in  = S_CADD;
         end
         S_CADD: begin
            cmd.c_add = 1'b1;
            state_in  = status.outside ? S_DONE : S_ZMUL;
         end
         S_ZMUL: begin
            cmd.z_mul = 1'b1;
            state_in  = S_ZUPD;
         end
         S_ZUPD: begin
            if (status.stop) begin
               state_in = S_DONE;
            end else begin
               cmd.z_update = 1'b1;
               state_in     = S_ZMUL;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/mbe_dp.sv -----
module mbe_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [mbe_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mbe_pkg::CSR_DATA_W-1:0]       csr_data,
   input  mbe_pkg::req_type                     req_data,
   output mbe_pkg::rsp_type                     rsp_data,
   input  mbe_pkg::cmd_type                     cmd,
   output mbe_pkg::status_type                  status
);
   import mbe_pkg::*;

   function automatic logic signed [31:0] sat_q(input logic signed [45:0] v);
      logic signed [31:0] r;
      if (v > 46'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -46'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic signed [31:0] x_start_ff, x_step_ff, y_start_ff, y_step_ff;
   logic [15:0]        max_iters_ff;
   logic [12:0]        line_width_ff;

   logic [11:0]        col_ff, row_ff;
   logic signed [44:0] xprod_ff, yprod_ff;
   logic [23:0]        idx_prod_ff, pix_idx_ff;
   logic               outside_ff;

   logic signed [31:0] c_real_ff, c_imag_ff, z_real_ff, z_imag_ff;
   logic [15:0]        iter_count_ff;
   logic signed [63:0] rr_ff, ii_ff, ri_ff;
   rsp_type            rsp_ff;

   logic signed [44:0] xprod_in, yprod_in;
   logic [24:0]        idx_prod_full;
   logic signed [45:0] cr_sum, ci_sum, nr_sum, ni_sum;
   logic signed [63:0] diff, diff_sh, ri_sh;
   logic [63:0]        norm;
   logic               escape;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_start_ff    <= '0;
         x_step_ff     <= '0;
         y_start_ff    <= '0;
         y_step_ff     <= '0;
         max_iters_ff  <= MAX_ITERS_RESET;
         line_width_ff <= LINE_WIDTH_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_X_START:    x_start_ff    <= csr_data;
            CSR_X_STEP:     x_step_ff     <= csr_data;
            CSR_Y_START:    y_start_ff    <= csr_data;
            CSR_Y_STEP:     y_step_ff     <= csr_data;
            CSR_MAX_ITERS:  max_iters_ff  <= csr_data[15:0];
            CSR_LINE_WIDTH: line_width_ff <= csr_data[12:0];
            default: begin
            end
         endcase
      end
   end

   assign xprod_in      = x_step_ff * $signed({1'b0, col_ff});
   assign yprod_in      = y_step_ff * $signed({1'b0, row_ff});
   assign idx_prod_full = row_ff * line_width_ff;

   assign cr_sum = $signed({xprod_ff[44], xprod_ff}) + $signed({{14{x_start_ff[31]}}, x_start_ff});
   assign ci_sum = $signed({yprod_ff[44], yprod_ff}) + $signed({{14{y_start_ff[31]}}, y_start_ff});

   assign diff    = rr_ff - ii_ff;
   assign diff_sh = diff >>> FRAC_BITS;
   assign ri_sh   = ri_ff >>> (FRAC_BITS - 1);
   assign nr_sum  = $signed(diff_sh[45:0]) + $signed({{14{c_real_ff[31]}}, c_real_ff});
   assign ni_sum  = $signed(ri_sh[45:0]) + $signed({{14{c_imag_ff[31]}}, c_imag_ff});

   assign norm   = rr_ff + ii_ff;
   assign escape = norm > ESCAPE_LIMIT;

   always_ff @(posedge clock) begin
      if (cmd.load_px) begin
         col_ff <= req_data.column;
         row_ff <= req_data.row;
      end
      if (cmd.c_mul) begin
         xprod_ff    <= xprod_in;
         yprod_ff    <= yprod_in;
         idx_prod_ff <= idx_prod_full[23:0];
         outside_ff  <= ({1'b0, col_ff} >= line_width_ff);
      end
      if (cmd.c_add) begin
         c_real_ff     <= sat_q(cr_sum);
         c_imag_ff     <= sat_q(ci_sum);
         pix_idx_ff    <= idx_prod_ff + {12'd0, col_ff};
         z_real_ff     <= '0;
         z_imag_ff     <= '0;
         iter_count_ff <= '0;
      end
      if (cmd.z_mul) begin
         rr_ff <= z_real_ff * z_real_ff;
         ii_ff <= z_imag_ff * z_imag_ff;
         ri_ff <= z_real_ff * z_imag_ff;
      end
      if (cmd.z_update) begin
         z_real_ff     <= sat_q(nr_sum);
         z_imag_ff     <= sat_q(ni_sum);
         iter_count_ff <= iter_count_ff + 16'd1;
      end
      if (cmd.load_rsp) begin
         if (outside_ff) begin
            rsp_ff <= '0;
         end else begin
            rsp_ff.iterations  <= iter_count_ff;
            rsp_ff.pixel_index <= pix_idx_ff;
            rsp_ff.written     <= 1'b1;
         end
      end
   end

   assign status.outside = outside_ff;
   assign status.stop    = (iter_count_ff != 16'd0) &&
                           (escape || (iter_count_ff >= max_iters_ff));
   assign rsp_data       = rsp_ff;

endmodule

// ----- tb/mandelbrot_escape_time_tb.sv -----
`timescale 1ns / 100ps

module mandelbrot_escape_time_tb;
   import mbe_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int          VIEW_PIXELS = 150;
   localparam int          VIEW_COUNT  = 12;
   localparam longint      Q_HIGH      = 64'sd2147483647;
   localparam longint      Q_LOW       = -64'sd2147483648;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   req_type               req_data     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_data     = '0;

   logic signed [31:0] view_x_start    = '0;
   logic signed [31:0] view_x_step     = '0;
   logic signed [31:0] view_y_start    = '0;
   logic signed [31:0] view_y_step     = '0;
   logic [15:0]        view_max_iters  = MAX_ITERS_RESET;
   logic [12:0]        view_line_width = LINE_WIDTH_RESET;

   rsp_type     pending_pixels[$];
   int          send_idle_pct  = 0;
   int          rsp_stall_pct  = 0;
   int unsigned cycle_count    = 0;
   int          mismatch_count = 0;
   int          pixels_sent    = 0;
   int          written_seen   = 0;
   int          views_loaded   = 0;

   mandelbrot_escape_time dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic longint clamp_q(longint v);
      if (v > Q_HIGH) return Q_HIGH;
      if (v < Q_LOW) return Q_LOW;
      return v;
   endfunction

   function automatic rsp_type escape_pixel(req_type px);
      rsp_type     r;
      longint      cr, ci, zr, zi;
      logic [63:0] norm;
      int unsigned n;
      int unsigned idx;
      bit          escaped;
      r = '0;
      if ({1'b0, px.column} >= view_line_width) return r;
      cr = clamp_q(longint'(view_x_start) + longint'(view_x_step) * longint'(px.column));
      ci = clamp_q(longint'(view_y_start) + longint'(view_y_step) * longint'(px.row));
      zr = 0;
      zi = 0;
      n = 0;
      do begin
         longint nr, ni;
         nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
         ni = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
         zr = clamp_q(nr);
         zi = clamp_q(ni);
         n++;
         norm = zr * zr + zi * zi;
         escaped = norm > ESCAPE_LIMIT;
      end while (!escaped && n < view_max_iters);
      idx = px.row * view_line_width + px.column;
      r.iterations  = n[15:0];
      r.pixel_index = idx[23:0];
      r.written     = 1'b1;
      return r;
   endfunction

   function automatic void flag_mismatch(string what, rsp_type got, rsp_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: got iter=%0d index=%0h written=%0b, want iter=%0d index=%0h written=%0b",
                  $realtime, what, got.iterations, got.pixel_index, got.written,
                  want.iterations, want.pixel_index, want.written);
   endfunction

   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : check_words
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            flag_mismatch("unexpected word", rsp_data, '0);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.iterations !== want.iterations ||
                rsp_data.pixel_index !== want.pixel_index ||
                rsp_data.written !== want.written) begin
               flag_mismatch("wrong word", rsp_data, want);
            end
            if (rsp_data.written === 1'b1) written_seen++;
         end
      end
   end

   task automatic send_pixel(input logic [11:0] column, input logic [11:0] row);
      req_type word;
      word.column = column;
      word.row    = row;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_pixels.push_back(escape_pixel(word));
      pixels_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= value;
      @(posedge clock);
   endtask

   task automatic set_view(input logic [31:0] xs, xst, ys, yst,
                           input logic [15:0] iters, input logic [12:0] width);
      wait_idle();
      write_csr(CSR_X_START, xs);
      write_csr(CSR_X_STEP, xst);
      write_csr(CSR_Y_START, ys);
      write_csr(CSR_Y_STEP, yst);
      write_csr(CSR_MAX_ITERS, {16'd0, iters});
      write_csr(CSR_LINE_WIDTH, {19'd0, width});
      csr_write_en <= 1'b0;
      view_x_start    = xs;
      view_x_step     = xst;
      view_y_start    = ys;
      view_y_step     = yst;
      view_max_iters  = iters;
      view_line_width = width;
      views_loaded++;
      @(posedge clock);
   endtask

   task automatic set_idle(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic test_reset_defaults();
      set_idle(0, 0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
   endtask

   task automatic test_line_edges();
      set_idle(0, 0);
      set_view(32'h0, 32'h0, 32'h0, 32'h0, 16'd1, 13'd1);
      send_pixel(12'd0, 12'd7);
      send_pixel(12'd1, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      set_view(32'h0, 32'h0, 32'h0, 32'h0, 16'd1, 13'd0);
      send_pixel(12'd0, 12'd0);
      set_view(32'h0100_0000, 32'h0000_1000, 32'h0, 32'h0, 16'd3, 13'd8191);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd4095);
   endtask

   task automatic test_iteration_limits();
      set_idle(0, 0);
      set_view(32'h0, 32'h0, 32'h0, 32'h0, 16'd0, 13'd4096);
      send_pixel(12'd5, 12'd9);
      set_view(32'h0, 32'h0, 32'h0, 32'h0, 16'd65535, 13'd4096);
      send_pixel(12'd0, 12'd0);
      set_view(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 16'd65535, 13'd4096);
      send_pixel(12'd0, 12'd0);
   endtask

   task automatic test_escape_boundary();
      set_idle(29, 29);
      // |z|^2 lands exactly on 4 and must not count as escaped
      set_view(32'hE000_0000, 32'h0, 32'h0, 32'h0, 16'd20, 13'd4096);
      send_pixel(12'd0, 12'd0);
      set_view(32'h2000_0000, 32'h0, 32'h0, 32'h0, 16'd20, 13'd4096);
      send_pixel(12'd0, 12'd0);
      set_view(32'h0, 32'h0, 32'h2000_0000, 32'h0, 16'd20, 13'd4096);
      send_pixel(12'd0, 12'd0);
   endtask

   task automatic test_saturation();
      set_idle(29, 29);
      set_view(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd8, 13'd4096);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd1);
      set_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'd8, 13'd4096);
      send_pixel(12'd4095, 12'd4095);
   endtask

   task automatic test_random_views();
      int          p, k, col_limit, mag;
      logic [31:0] xs, xst, ys, yst;
      logic [15:0] iters;
      logic [12:0] width;
      logic [11:0] column;
      for (p = 0; p < VIEW_COUNT; p++) begin
         case (p % 4)
            0: set_idle(0, 0);
            1: set_idle(51, 0);
            2: set_idle(0, 51);
            default: set_idle(29, 29);
         endcase
         case ($urandom_range(0, 4))
            0: width = 13'd1;
            1: width = 13'd4096;
            2: width = 13'($urandom_range(4097, 8191));
            default: width = 13'($urandom_range(2, 4096));
         endcase
         col_limit = (width > 13'd4096) ? 4096 : int'(width);
         if (p == 5) iters = 16'd256;
         else if (p == 2) iters = 16'd1;
         else iters = 16'($urandom_range(1, 40));
         if (p % 4 == 3) begin
            xs  = $urandom();
            xst = $urandom();
            ys  = $urandom();
            yst = $urandom();
         end else begin
            xs  = -671088640 + int'($urandom_range(0, 939524096));
            mag = int'($urandom_range(1, 805306368 / col_limit));
            xst = $urandom_range(0, 1) ? -mag : mag;
            ys  = -536870912 + int'($urandom_range(0, 1073741824));
            mag = int'($urandom_range(1, 196608));
            yst = $urandom_range(0, 1) ? -mag : mag;
         end
         set_view(xs, xst, ys, yst, iters, width);
         for (k = 0; k < VIEW_PIXELS; k++) begin
            if ($urandom_range(0, 99) < 85) column = 12'($urandom_range(0, col_limit - 1));
            else column = 12'($urandom_range(0, 4095));
            send_pixel(column, 12'($urandom_range(0, 4095)));
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_line_edges();
      test_iteration_limits();
      test_escape_boundary();
      test_saturation();
      test_random_views();
      wait_idle();
      repeat (16) @(posedge clock);
      $display("Covered %0d pixels over %0d register settings, %0d of them stored.",
               pixels_sent, views_loaded, written_seen);
      $display("Limits from 0 to 65535, line widths 0 to 8191, idle and stall mixes varied.");
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_ctrl.sv
hw/rtl/mbe_dp.sv
hw/rtl/mandelbrot_escape_time.sv
tb/mandelbrot_escape_time_tb.sv
